/* hw/rtl/radix_alphabet_encoder_defines.svh */
// assertion macros for the radix alphabet encoder
`ifndef RADIX_ALPHABET_ENCODER_DEFINES_SVH
`define RADIX_ALPHABET_ENCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on i_clk, off during reset
`define RAE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("radix_alphabet_encoder: same-cycle check failed");

// next-cycle implication, sampled on i_clk, off during reset
`define RAE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("radix_alphabet_encoder: next-cycle check failed");

`else

`define RAE_ASSERT_NOW(label, ante, cons)
`define RAE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hw/rtl/rae_pkg.sv */
// shared types, codes and character mapping for the radix alphabet encoder
`default_nettype none

package rae_pkg;

    typedef enum logic [1:0] {
        MODE_B16    = 2'd0,
        MODE_B32    = 2'd1,
        MODE_B32HEX = 2'd2,
        MODE_B64    = 2'd3
    } t_mode;

    localparam int unsigned MaxChars = 8;
    localparam logic [7:0]  PadChar  = 8'h3D;

    // characters one input byte produces, in emit order
    typedef struct packed {
        logic [MaxChars-1:0][7:0] chars;
        logic [3:0]               count;
        logic                     fin;
    } t_result;

    // symbol value to ascii, per alphabet
    function automatic logic [7:0] map_symbol(t_mode mode, logic [5:0] sym);
        logic [7:0] s;
        logic [7:0] c;
        s = {2'b00, sym};
        c = 8'h00;
        case (mode)
            MODE_B16, MODE_B32HEX: begin
                c = (s < 8'd10) ? (8'h30 + s) : (8'h41 + s - 8'd10);
            end
            MODE_B32: begin
                c = (s < 8'd26) ? (8'h41 + s) : (8'h32 + s - 8'd26);
            end
            MODE_B64: begin
                if (s < 8'd26)      c = 8'h41 + s;
                else if (s < 8'd52) c = 8'h61 + s - 8'd26;
                else if (s < 8'd62) c = 8'h30 + s - 8'd52;
                else if (s == 8'd62) c = 8'h2B;
                else                c = 8'h2F;
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/rae_encode_core.sv */
// combinational symbol split, flush and padding for one input byte
`default_nettype none

module rae_encode_core (
    input  wire rae_pkg::t_mode   i_mode,
    input  wire logic [5:0]       i_part,
    input  wire logic [2:0]       i_cnt,
    input  wire logic [2:0]       i_pos,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_fin,
    output rae_pkg::t_result      o_res,
    output logic [5:0]            o_part,
    output logic [2:0]            o_cnt,
    output logic [2:0]            o_pos
);
    import rae_pkg::*;

    logic [2:0]  w;
    logic [5:0]  mask6;
    logic [2:0]  cntc;
    logic [13:0] acc;
    logic [3:0]  total;
    logic [2:0]  grp_ok;
    logic [5:0]  grp_sym [3];
    logic [1:0]  n1;
    logic [3:0]  rem;
    logic [5:0]  acc_rem;
    logic        flush;
    logic [7:0]  flush_char;
    logic [2:0]  kpos;
    logic [2:0]  pads;
    logic [3:0]  pos_inc;
    logic [2:0]  gbytes;
    logic [4:0]  sum;

    always_comb begin
        case (i_mode)
            MODE_B16: begin w = 3'd4; mask6 = 6'h0F; gbytes = 3'd1; end
            MODE_B64: begin w = 3'd6; mask6 = 6'h3F; gbytes = 3'd3; end
            default:  begin w = 3'd5; mask6 = 6'h1F; gbytes = 3'd5; end
        endcase
    end

    always_comb begin
        logic [4:0] thr;
        logic [3:0] sh;
        cntc  = (i_cnt > 3'd6) ? 3'd6 : i_cnt;
        acc   = {i_part & ~(6'h3F << cntc), i_byte};
        total = 4'(cntc) + 4'd8;
        for (int i = 0; i < 3; i++) begin
            thr        = 5'(i + 1) * 5'(w);
            grp_ok[i]  = 5'(total) >= thr;
            sh         = 4'(5'(total) - thr);
            grp_sym[i] = 6'(acc >> sh) & mask6;
        end
        n1 = 2'(grp_ok[0]) + 2'(grp_ok[1]) + 2'(grp_ok[2]);
        case (n1)
            2'd0:    rem = total;
            2'd1:    rem = total - 4'(w);
            2'd2:    rem = total - 4'(w) - 4'(w);
            default: rem = total - 4'(w) - 4'(w) - 4'(w);
        endcase
        acc_rem    = 6'(acc & ~(14'h3FFF << rem));
        flush      = i_fin && (rem != 4'd0);
        flush_char = map_symbol(i_mode, 6'(acc_rem << (4'(w) - rem)) & mask6);
    end

    // bytes already in the group, reduced modulo the group size
    always_comb begin
        case (i_mode)
            MODE_B16: kpos = 3'd0;
            MODE_B64: begin
                case (i_pos)
                    3'd0, 3'd3, 3'd6: kpos = 3'd0;
                    3'd1, 3'd4, 3'd7: kpos = 3'd1;
                    default:          kpos = 3'd2;
                endcase
            end
            default: kpos = (i_pos >= 3'd5) ? (i_pos - 3'd5) : i_pos;
        endcase
    end

    // pad count once this final byte closes the group
    always_comb begin
        pads = 3'd0;
        case (i_mode)
            MODE_B64: begin
                case (kpos)
                    3'd0:    pads = 3'd2;
                    3'd1:    pads = 3'd1;
                    default: pads = 3'd0;
                endcase
            end
            MODE_B32, MODE_B32HEX: begin
                case (kpos)
                    3'd0:    pads = 3'd6;
                    3'd1:    pads = 3'd4;
                    3'd2:    pads = 3'd3;
                    3'd3:    pads = 3'd1;
                    default: pads = 3'd0;
                endcase
            end
            default: pads = 3'd0;
        endcase
    end

    always_comb begin
        for (int j = 0; j < MaxChars; j++) begin
            o_res.chars[j] = PadChar;
        end
        for (int i = 0; i < 3; i++) begin
            if (grp_ok[i]) o_res.chars[i] = map_symbol(i_mode, grp_sym[i]);
        end
        for (int j = 0; j < 4; j++) begin
            if (flush && (2'(j) == n1)) o_res.chars[j] = flush_char;
        end
        sum = 5'(n1);
        if (i_fin) sum = 5'(n1) + 5'(flush) + 5'(pads);
        o_res.count = (sum > 5'(MaxChars)) ? 4'(MaxChars) : 4'(sum);
        o_res.fin   = i_fin;
    end

    always_comb begin
        pos_inc = 4'(i_pos) + 4'd1;
        if (i_fin) begin
            o_part = 6'd0;
            o_cnt  = 3'd0;
            o_pos  = 3'd0;
        end else begin
            o_part = acc_rem;
            o_cnt  = rem[2:0];
            o_pos  = (pos_inc >= 4'(gbytes)) ? 3'd0 : pos_inc[2:0];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rae_char_serializer.sv */
// result register that hands out one character per beat
`default_nettype none

module rae_char_serializer (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load_valid,
    input  wire rae_pkg::t_result i_res,
    output logic                  o_load_ready,
    output logic                  o_tvalid,
    input  wire logic             i_tready,
    output logic [7:0]            o_tdata,
    output logic                  o_tlast
);
    import rae_pkg::*;

    t_result    r_res;
    logic       r_valid;
    logic [2:0] r_idx;
    logic       at_end;
    logic       take;

    assign at_end       = (4'(r_idx) + 4'd1) == r_res.count;
    assign take         = r_valid && i_tready;
    assign o_load_ready = !r_valid || (take && at_end);
    assign o_tvalid     = r_valid;
    assign o_tdata      = r_res.chars[r_idx];
    assign o_tlast      = r_res.fin && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (o_load_ready && i_load_valid) begin
            r_valid <= i_res.count != 4'd0;
            r_idx   <= 3'd0;
        end else if (take && at_end) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load_ready && i_load_valid) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/radix_alphabet_encoder.sv */
// top level of the base16 / base32 / base32hex / base64 stream encoder
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+-------------------------------------
//  s (in)   | in  | i_s_tvalid / o_s_tready | i_s_tdata = data_byte, i_s_tlast = final_byte
//  m (out)  | out | o_m_tvalid / i_m_tready | o_m_tdata = out_char, o_m_tlast = last_char
//  cfg      | in  | i_cfg_valid / o_cfg_ready | i_cfg_data = alphabet_mode
//
// one output character per cycle while the output side is ready; each byte yields
// one or two characters for a plain byte, up to eight for a padded final byte
// the result register drains at one character a beat and sets the pace; the input
// register is refilled in the cycle the previous byte moves into the result register
// synchronous active-low reset: mode back to base64, bit accumulator and group position
// cleared; a mode write also clears them and starts a new message
// a stall on the output side holds the current character and backs up into the input side
`default_nettype none
`include "radix_alphabet_encoder_defines.svh"

module radix_alphabet_encoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input byte stream
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  wire logic       i_s_tlast,   // final_byte
    // output character stream
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] out_char
    output logic            o_m_tlast,   // last_char
    // mode register write
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_data   // [1:0] alphabet_mode
);
    import rae_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_fin;

    // mode and bit accumulator state
    t_mode      r_mode;
    logic [5:0] r_part;
    logic [2:0] r_cnt;
    logic [2:0] r_pos;

    t_result    core_res;
    logic [5:0] n_part;
    logic [2:0] n_cnt;
    logic [2:0] n_pos;
    logic       ser_ready;
    logic       adv;
    logic       cfg_wr;

    // held byte moves to the result register when the serializer can take it
    assign adv         = r_in_valid && ser_ready;
    assign o_s_tready  = !r_in_valid || adv;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_fin  <= i_s_tlast;
        end
    end

    // mode writes must arrive only while idle, which the block does not enforce; a write wins over an advancing byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_B64;
            r_part <= 6'd0;
            r_cnt  <= 3'd0;
            r_pos  <= 3'd0;
        end else if (cfg_wr) begin
            r_mode <= t_mode'(i_cfg_data);
            r_part <= 6'd0;
            r_cnt  <= 3'd0;
            r_pos  <= 3'd0;
        end else if (adv) begin
            r_part <= n_part;
            r_cnt  <= n_cnt;
            r_pos  <= n_pos;
        end
    end

    rae_encode_core u_core (
        .i_mode (r_mode),
        .i_part (r_part),
        .i_cnt  (r_cnt),
        .i_pos  (r_pos),
        .i_byte (r_in_byte),
        .i_fin  (r_in_fin),
        .o_res  (core_res),
        .o_part (n_part),
        .o_cnt  (n_cnt),
        .o_pos  (n_pos)
    );

    rae_char_serializer u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (r_in_valid),
        .i_res        (core_res),
        .o_load_ready (ser_ready),
        .o_tvalid     (o_m_tvalid),
        .i_tready     (i_m_tready),
        .o_tdata      (o_m_tdata),
        .o_tlast      (o_m_tlast)
    );

    // a mode write starts a fresh message
    `RAE_ASSERT_NEXT(a_cfg_clears, cfg_wr,
        (r_cnt == 3'd0) && (r_pos == 3'd0) && (r_part == 6'd0))
    // leftover bits never exceed five, and stay under four in base16
    `RAE_ASSERT_NOW(a_cnt_range, 1'b1,
        (r_cnt <= 3'd5) && ((r_mode != MODE_B16) || (r_cnt < 3'd4)))
    // group position stays inside the group
    `RAE_ASSERT_NOW(a_pos_range, 1'b1,
        (r_pos < 3'd5) && ((r_mode != MODE_B64) || (r_pos < 3'd3))
        && ((r_mode != MODE_B16) || (r_pos == 3'd0)))
    // a byte is only taken into a full input register when the held one advances
    `RAE_ASSERT_NOW(a_no_overwrite, o_s_tready && r_in_valid, adv)

endmodule

`default_nettype wire

/* test/radix_alphabet_encoder_tb.sv */
`timescale 1ns / 1ps
// self-checking bench for the radix alphabet encoder: random byte messages in, checked text out

module radix_alphabet_encoder_tb;
    import rae_pkg::*;

    localparam int CycleLimit   = 200000;
    localparam int SettleCycles = 12;
    localparam int RandomBytes  = 105;

    // one expected output beat
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    // one input beat
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } t_msg_byte;

    // tracks the encoder state and the characters still owed by the block
    class radix_text_scoreboard;
        t_mode      mode;
        logic [5:0] held_bits;
        int         held_count;
        int         group_pos;
        t_text_char pending_chars[$];
        int         errors;
        int         chars_checked;

        function new();
            set_mode(MODE_B64);
            errors = 0;
            chars_checked = 0;
        endfunction

        // a mode write also drops any message in progress
        function void set_mode(t_mode m);
            mode = m;
            held_bits = '0;
            held_count = 0;
            group_pos = 0;
        endfunction

        function logic [7:0] symbol_char(int sym);
            string hex_set;
            string b32_set;
            string b32x_set;
            string b64_set;
            hex_set  = "0123456789ABCDEF";
            b32_set  = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
            b32x_set = "0123456789ABCDEFGHIJKLMNOPQRSTUV";
            b64_set  = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            case (mode)
                MODE_B16:    return hex_set[sym & 15];
                MODE_B32:    return b32_set[sym & 31];
                MODE_B32HEX: return b32x_set[sym & 31];
                default:     return b64_set[sym & 63];
            endcase
        endfunction

        // works out the characters one accepted byte produces
        function void note_byte(logic [7:0] data, logic fin);
            int         width;
            int         group_len;
            int         mask;
            int         acc;
            int         total;
            int         full;
            int         used;
            int         pads;
            t_text_char tc;
            t_text_char produced[$];
            width     = (mode == MODE_B16) ? 4 : (mode == MODE_B64) ? 6 : 5;
            group_len = (mode == MODE_B16) ? 1 : (mode == MODE_B64) ? 3 : 5;
            mask      = (1 << width) - 1;
            acc       = ((int'(held_bits) & ((1 << held_count) - 1)) << 8) | int'(data);
            total     = held_count + 8;
            tc.last   = 1'b0;
            while (total >= width) begin
                total -= width;
                tc.ch = symbol_char((acc >> total) & mask);
                produced.push_back(tc);
            end
            acc &= (1 << total) - 1;
            if (!fin) begin
                group_pos  = (group_pos + 1 >= group_len) ? 0 : group_pos + 1;
                held_bits  = acc[5:0];
                held_count = total;
            end else begin
                // leftover bits are zero filled on the right
                if (total > 0) begin
                    tc.ch = symbol_char((acc << (width - total)) & mask);
                    produced.push_back(tc);
                end
                // pad out the rest of the group
                full = (8 * group_len) / width;
                used = (8 * (group_pos % group_len + 1) + width - 1) / width;
                pads = (used < full) ? full - used : 0;
                tc.ch = PadChar;
                repeat (pads) produced.push_back(tc);
                set_mode(mode);
            end
            foreach (produced[i]) begin
                tc = produced[i];
                tc.last = fin && (i == produced.size() - 1);
                pending_chars.push_back(tc);
            end
        endfunction

        function void check_char(logic [7:0] ch, logic last);
            t_text_char want;
            chars_checked++;
            if (pending_chars.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected char %h last %b", ch, last);
                return;
            end
            want = pending_chars.pop_front();
            if (want.ch !== ch || want.last !== last) begin
                errors++;
                if (errors <= 10)
                    $display("char mismatch: expected %h last %b, got %h last %b",
                             want.ch, want.last, ch, last);
            end
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_s_tvalid  = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata   = '0;     // [7:0] data_byte
    logic       i_s_tlast   = 1'b0;   // final_byte
    logic       o_m_tvalid;
    logic       i_m_tready  = 1'b0;
    logic [7:0] o_m_tdata;            // [7:0] out_char
    logic       o_m_tlast;            // last_char
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_data  = MODE_B64;

    radix_text_scoreboard board;
    t_msg_byte            msg_q[$];
    bit                   steady        = 1'b0;
    bit                   s_busy        = 1'b0;
    int                   bytes_sent    = 0;
    int                   messages_sent = 0;
    int                   mode_writes   = 0;
    int                   cycle_count   = 0;

    radix_alphabet_encoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // idle cycles before the next beat on either side
    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 15);
    endfunction

    // drives every queued byte, valid held high across back-to-back beats
    task automatic send_queued();
        int        gap;
        t_msg_byte b;
        gap = draw_gap();
        // valid was lowered at the end of the last call, so force a gap before raising it again
        if (!s_busy && gap == 0)
            gap = 1;
        while (msg_q.size() > 0) begin
            b = msg_q.pop_front();
            if (gap > 0) begin
                if (s_busy) begin
                    i_s_tvalid <= 1'b0;
                    s_busy = 1'b0;
                end
                repeat (gap) @(posedge i_clk);
            end
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= b.data;
            i_s_tlast  <= b.fin;
            s_busy = 1'b1;
            @(posedge i_clk);
            while (!o_s_tready) @(posedge i_clk);
            board.note_byte(b.data, b.fin);
            bytes_sent++;
            if (b.fin)
                messages_sent++;
            gap = draw_gap();
        end
        if (s_busy) begin
            i_s_tvalid <= 1'b0;
            s_busy = 1'b0;
        end
    endtask

    task automatic wait_drained();
        while (board.pending_chars.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // mode writes only go in once the block has nothing left to emit
    task automatic write_mode(t_mode m);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.set_mode(m);
        mode_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    // output side: random stalls, every accepted beat checked
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
            board.check_char(o_m_tdata, o_m_tlast);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("radix_alphabet_encoder_tb: done, errors");
            $finish;
        end
    end

    initial begin
        int        start;
        int        len;
        bit        abandon;
        bit        stop;
        t_msg_byte mb;
        board = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // base64 after reset: two pads, one pad, no pad, extremes
        msg_q.push_back('{data: 8'h00, fin: 1'b1});
        msg_q.push_back('{data: 8'hFF, fin: 1'b0});
        msg_q.push_back('{data: 8'h00, fin: 1'b1});
        msg_q.push_back('{data: 8'hFF, fin: 1'b0});
        msg_q.push_back('{data: 8'hFF, fin: 1'b0});
        msg_q.push_back('{data: 8'hFF, fin: 1'b1});
        msg_q.push_back('{data: 8'h66, fin: 1'b1});
        send_queued();

        // base32: six pads on a one byte message, then a full group
        write_mode(MODE_B32);
        msg_q.push_back('{data: 8'hFF, fin: 1'b1});
        msg_q.push_back('{data: 8'h00, fin: 1'b0});
        msg_q.push_back('{data: 8'hFF, fin: 1'b0});
        msg_q.push_back('{data: 8'h5A, fin: 1'b0});
        msg_q.push_back('{data: 8'hA5, fin: 1'b0});
        msg_q.push_back('{data: 8'h81, fin: 1'b1});
        send_queued();

        write_mode(MODE_B32HEX);
        msg_q.push_back('{data: 8'hA5, fin: 1'b0});
        msg_q.push_back('{data: 8'h3C, fin: 1'b1});
        send_queued();

        // base16 never pads
        write_mode(MODE_B16);
        msg_q.push_back('{data: 8'h00, fin: 1'b0});
        msg_q.push_back('{data: 8'hFF, fin: 1'b1});
        send_queued();

        // message cut short by a mode write, leftover bits must be dropped
        write_mode(MODE_B64);
        msg_q.push_back('{data: 8'hFF, fin: 1'b0});
        send_queued();
        write_mode(MODE_B64);
        msg_q.push_back('{data: 8'h80, fin: 1'b1});
        send_queued();

        // random phases: mode write, then a few messages of random bytes
        start = bytes_sent;
        while (bytes_sent - start < RandomBytes) begin
            steady = ($urandom_range(0, 3) == 0);
            write_mode(t_mode'($urandom_range(0, 3)));
            stop = 1'b0;
            for (int m = $urandom_range(1, 4); m > 0 && !stop; m--) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20)
                                                  : $urandom_range(1, 8);
                // now and then leave the message open for the next mode write
                abandon = ($urandom_range(0, 9) == 0);
                for (int i = 0; i < len; i++) begin
                    mb.data = $urandom_range(0, 255);
                    mb.fin  = (i == len - 1) && !abandon;
                    msg_q.push_back(mb);
                end
                stop = abandon;
                // hold the input off until the text so far has drained
                if ($urandom_range(0, 3) == 0) begin
                    send_queued();
                    wait_drained();
                end
            end
            send_queued();
        end
        steady = 1'b0;
        wait_drained();

        $display("sent %0d bytes in %0d finished messages over %0d mode writes",
                 bytes_sent, messages_sent, mode_writes);
        $display("checked %0d characters, %0d mismatches",
                 board.chars_checked, board.errors);
        if (board.errors == 0 && board.pending_chars.size() == 0) begin
            $display("radix_alphabet_encoder_tb: done, clean");
        end else begin
            $display("radix_alphabet_encoder_tb: done, errors");
        end
        $finish;
    end

endmodule
